// File: hw/rtl/mifd_pkg.sv
package mifd_pkg;

  // access kinds
  localparam logic [1:0] ACC_NONE   = 2'd0;
  localparam logic [1:0] ACC_READ   = 2'd1;
  localparam logic [1:0] ACC_WRITE  = 2'd2;
  localparam logic [1:0] ACC_BRANCH = 2'd3;

  // pseudo destinations
  localparam logic [5:0] IDX_PC = 6'd32;
  localparam logic [5:0] IDX_HL = 6'd33;

  // primary opcodes decoded singly
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  // function codes decoded singly
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;

  // coprocessor rs code for branch-on-condition
  localparam logic [4:0] CP_BC = 5'd8;

  typedef struct packed {
    logic [5:0]  primary_op;
    logic [5:0]  secondary_op;
    logic [5:0]  left_reg;
    logic [4:0]  right_reg;
    logic [5:0]  dest_reg;
    logic [4:0]  link_reg;
    logic [31:0] immediate;
    logic [1:0]  access_kind;
    logic [4:0]  coproc_function;
    logic [2:0]  writeback_unit;
  } dec_t;

endpackage

// File: hw/rtl/mifd_decode.sv
module mifd_decode (
  input  logic [31:0]   word,
  output mifd_pkg::dec_t dec
);
  import mifd_pkg::*;

  logic [5:0]  p;
  logic [5:0]  f;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] sext;
  logic [31:0] zext;

  assign p    = word[31:26];
  assign f    = word[5:0];
  assign rs   = word[25:21];
  assign rt   = word[20:16];
  assign rd   = word[15:11];
  assign sext = {{16{word[15]}}, word[15:0]};
  assign zext = {16'd0, word[15:0]};

  always_comb begin
    dec                 = '0;
    dec.primary_op      = p;
    dec.secondary_op    = f;
    case (p) inside
      OP_SPECIAL: begin
        case (f) inside
          [6'h00:6'h03]: begin
            dec.immediate = {27'd0, word[10:6]};
            dec.left_reg  = {1'b0, rt};
            dec.dest_reg  = {1'b0, rd};
          end
          [6'h04:6'h07], [6'h20:6'h3F]: begin
            dec.left_reg  = {1'b0, rs};
            dec.right_reg = rt;
            dec.dest_reg  = {1'b0, rd};
          end
          FN_JR: begin
            dec.left_reg    = {1'b0, rs};
            dec.dest_reg    = IDX_PC;
            dec.access_kind = ACC_BRANCH;
          end
          FN_JALR: begin
            dec.left_reg    = {1'b0, rs};
            dec.dest_reg    = IDX_PC;
            dec.link_reg    = rd;
            dec.access_kind = ACC_BRANCH;
          end
          [6'h0C:6'h0D]: begin
            dec.immediate = {12'd0, word[25:6]};
          end
          FN_MFHI, FN_MFLO: begin
            dec.dest_reg = {1'b0, rd};
          end
          FN_MTHI, FN_MTLO: begin
            dec.left_reg = {1'b0, rs};
            dec.dest_reg = IDX_HL;
          end
          [6'h18:6'h1B]: begin
            dec.left_reg  = {1'b0, rs};
            dec.right_reg = rt;
            dec.dest_reg  = IDX_HL;
          end
          default: begin
          end
        endcase
      end
      OP_REGIMM, [6'h04:6'h05]: begin
        dec.left_reg    = {1'b0, rs};
        dec.right_reg   = rt;
        dec.immediate   = sext;
        dec.access_kind = ACC_BRANCH;
      end
      [6'h02:6'h03]: begin
        dec.immediate   = {6'd0, word[25:0]};
        dec.dest_reg    = IDX_PC;
        dec.access_kind = ACC_BRANCH;
      end
      [6'h06:6'h07]: begin
        dec.left_reg    = {1'b0, rs};
        dec.immediate   = sext;
        dec.access_kind = ACC_BRANCH;
      end
      OP_LUI: begin
        dec.immediate = zext;
        dec.dest_reg  = {1'b0, rt};
      end
      [6'h08:6'h0E]: begin
        dec.left_reg  = {1'b0, rs};
        dec.immediate = sext;
        dec.dest_reg  = {1'b0, rt};
      end
      [6'h10:6'h1F]: begin
        dec.coproc_function = rs;
        // rs bit 1 marks the control register space, offset by 32
        case (rs) inside
          [5'd0:5'd3]: begin
            dec.dest_reg = {1'b0, rt};
            dec.left_reg = {rs[1], rd};
          end
          [5'd4:5'd7]: begin
            dec.writeback_unit = p[2:0];
            dec.dest_reg       = {rs[1], rd};
            dec.left_reg       = {1'b0, rt};
          end
          CP_BC: begin
            dec.right_reg = rt;
            dec.immediate = sext;
          end
          [5'd16:5'd31]: begin
            dec.immediate = {7'd0, word[24:0]};
          end
          default: begin
          end
        endcase
      end
      [6'h20:6'h27]: begin
        dec.left_reg    = {1'b0, rs};
        dec.immediate   = zext;
        dec.dest_reg    = {1'b0, rt};
        dec.access_kind = ACC_READ;
      end
      [6'h30:6'h37]: begin
        dec.writeback_unit = p[2:0];
        dec.left_reg       = {1'b0, rs};
        dec.immediate      = zext;
        dec.dest_reg       = {1'b0, rt};
        dec.access_kind    = ACC_READ;
      end
      default: begin
        // stores, coprocessor stores and every other opcode not matched above
        dec.left_reg    = {1'b0, rs};
        dec.right_reg   = rt;
        dec.immediate   = zext;
        dec.access_kind = ACC_WRITE;
      end
    endcase
  end

endmodule

// File: hw/rtl/mips_instruction_field_decoder_core.sv
// Path: an accepted item is held in the input register, decoded, and captured in
//   the result register, whose valid drives out_valid.
// Throughput: one item per cycle; the decode is a single registered pass and
//   both stages advance together whenever the result is taken or empty.
// Reset: synchronous, active low; clears both stage valids, payload unreset.
module mips_instruction_field_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction_word,
  input  logic [31:0] in_instruction_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_primary_op,
  output logic [5:0]  out_secondary_op,
  output logic [5:0]  out_left_reg,
  output logic [4:0]  out_right_reg,
  output logic [5:0]  out_dest_reg,
  output logic [4:0]  out_link_reg,
  output logic [31:0] out_immediate,
  output logic [1:0]  out_access_kind,
  output logic [4:0]  out_coproc_function,
  output logic [2:0]  out_writeback_unit,
  output logic [31:0] out_decoded_address
);
  import mifd_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_word_r;
  logic [31:0] s1_addr_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  dec_t        out_dec_r;
  logic [31:0] out_addr_r;
  dec_t        dec;
  logic        out_adv;
  logic        in_take;

  mifd_decode u_decode (
    .word (s1_word_r),
    .dec  (dec)
  );

  // result stage loads when empty or being drained
  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_instruction_word;
      s1_addr_r <= in_instruction_address;
    end
    if (out_adv && s1_valid_r) begin
      out_dec_r  <= dec;
      out_addr_r <= s1_addr_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_primary_op      = out_dec_r.primary_op;
  assign out_secondary_op    = out_dec_r.secondary_op;
  assign out_left_reg        = out_dec_r.left_reg;
  assign out_right_reg       = out_dec_r.right_reg;
  assign out_dest_reg        = out_dec_r.dest_reg;
  assign out_link_reg        = out_dec_r.link_reg;
  assign out_immediate       = out_dec_r.immediate;
  assign out_access_kind     = out_dec_r.access_kind;
  assign out_coproc_function = out_dec_r.coproc_function;
  assign out_writeback_unit  = out_dec_r.writeback_unit;
  assign out_decoded_address = out_addr_r;

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted item not held in input stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_word_r))
    else $error("input stage lost its item during a stall");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input refused while there was room");

  a_link_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_link_reg != 5'd0 |-> out_access_kind == ACC_BRANCH)
    else $error("link register set on a non-branch");

  a_wb_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_writeback_unit != 3'd0 |->
      out_primary_op[5:4] == 2'b01 || out_primary_op[5:3] == 3'b110)
    else $error("writeback unit set outside coprocessor classes");

endmodule

// File: dv/mips_instruction_field_decoder_core_tb.sv
module mips_instruction_field_decoder_core_tb;
  import mifd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // opcodes and function codes not named in the package
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BLEZ  = 6'h06;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_COP0  = 6'h10;
  localparam logic [5:0] OP_COP1  = 6'h11;
  localparam logic [5:0] OP_COP2  = 6'h12;
  localparam logic [5:0] OP_COP3  = 6'h13;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_LWC0  = 6'h30;
  localparam logic [5:0] OP_LWC1  = 6'h31;
  localparam logic [5:0] OP_SWC2  = 6'h3A;

  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_MOVCI   = 6'h01;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_SYNC    = 6'h0F;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_LAST    = 6'h3F;

  // coprocessor rs codes
  localparam logic [4:0] CP_MF = 5'd0;
  localparam logic [4:0] CP_CF = 5'd2;
  localparam logic [4:0] CP_MT = 5'd4;
  localparam logic [4:0] CP_CT = 5'd6;
  localparam logic [4:0] CP_CO = 5'd16;

  typedef struct packed {
    dec_t        fields;
    logic [31:0] address;
  } decoded_instr_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction_word = '0;
  logic [31:0] in_instruction_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_primary_op;
  logic [5:0]  out_secondary_op;
  logic [5:0]  out_left_reg;
  logic [4:0]  out_right_reg;
  logic [5:0]  out_dest_reg;
  logic [4:0]  out_link_reg;
  logic [31:0] out_immediate;
  logic [1:0]  out_access_kind;
  logic [4:0]  out_coproc_function;
  logic [2:0]  out_writeback_unit;
  logic [31:0] out_decoded_address;

  decoded_instr_t pending_decodes[$];
  int unsigned    sent_count = 0;
  int unsigned    directed_count = 0;
  int unsigned    checked_count = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left = 0;
  bit             idle_en = 1'b0;

  mips_instruction_field_decoder_core DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_instruction_word    (in_instruction_word),
    .in_instruction_address (in_instruction_address),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_primary_op         (out_primary_op),
    .out_secondary_op       (out_secondary_op),
    .out_left_reg           (out_left_reg),
    .out_right_reg          (out_right_reg),
    .out_dest_reg           (out_dest_reg),
    .out_link_reg           (out_link_reg),
    .out_immediate          (out_immediate),
    .out_access_kind        (out_access_kind),
    .out_coproc_function    (out_coproc_function),
    .out_writeback_unit     (out_writeback_unit),
    .out_decoded_address    (out_decoded_address)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] enc_r(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [4:0] rd,
                                        input logic [4:0] sh, input logic [5:0] fn);
    return {op, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic decoded_instr_t predict_decode(input logic [31:0] w,
                                                    input logic [31:0] addr);
    decoded_instr_t r;
    logic [5:0]  p;
    logic [5:0]  f;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  ctl;
    logic [31:0] sext;
    logic [31:0] zext;
    r = '0;
    p = w[31:26];
    f = w[5:0];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sext = {{16{w[15]}}, w[15:0]};
    zext = {16'h0, w[15:0]};
    ctl = rs[1] ? 6'd32 : 6'd0;
    r.fields.primary_op = p;
    r.fields.secondary_op = f;
    r.address = addr;
    if (p == OP_SPECIAL) begin
      if (f[5:2] == 4'd0) begin
        r.fields.immediate = {27'h0, w[10:6]};
        r.fields.left_reg = {1'b0, rt};
        r.fields.dest_reg = {1'b0, rd};
      end else if (f[5:3] == 3'd0) begin
        r.fields.left_reg = {1'b0, rs};
        r.fields.right_reg = rt;
        r.fields.dest_reg = {1'b0, rd};
      end else if (f == FN_JR || f == FN_JALR) begin
        r.fields.left_reg = {1'b0, rs};
        r.fields.dest_reg = IDX_PC;
        r.fields.access_kind = ACC_BRANCH;
        if (f == FN_JALR) r.fields.link_reg = rd;
      end else if (f == FN_SYSCALL || f == FN_BREAK) begin
        r.fields.immediate = {12'h0, w[25:6]};
      end else if (f == FN_MFHI || f == FN_MFLO) begin
        r.fields.dest_reg = {1'b0, rd};
      end else if (f == FN_MTHI || f == FN_MTLO) begin
        r.fields.dest_reg = IDX_HL;
        r.fields.left_reg = {1'b0, rs};
      end else if (f[5:2] == FN_MULT[5:2]) begin
        r.fields.left_reg = {1'b0, rs};
        r.fields.right_reg = rt;
        r.fields.dest_reg = IDX_HL;
      end else if (f[5]) begin
        r.fields.left_reg = {1'b0, rs};
        r.fields.right_reg = rt;
        r.fields.dest_reg = {1'b0, rd};
      end
    end else if (p == OP_REGIMM || p[5:1] == OP_BEQ[5:1]) begin
      r.fields.left_reg = {1'b0, rs};
      r.fields.right_reg = rt;
      r.fields.immediate = sext;
      r.fields.access_kind = ACC_BRANCH;
    end else if (p[5:1] == OP_J[5:1]) begin
      r.fields.immediate = {6'h0, w[25:0]};
      r.fields.dest_reg = IDX_PC;
      r.fields.access_kind = ACC_BRANCH;
    end else if (p[5:1] == OP_BLEZ[5:1]) begin
      r.fields.left_reg = {1'b0, rs};
      r.fields.immediate = sext;
      r.fields.access_kind = ACC_BRANCH;
    end else if (p == OP_LUI) begin
      r.fields.immediate = zext;
      r.fields.dest_reg = {1'b0, rt};
    end else if (p[5:3] == OP_ADDI[5:3]) begin
      r.fields.left_reg = {1'b0, rs};
      r.fields.immediate = sext;
      r.fields.dest_reg = {1'b0, rt};
    end else if (p[5:3] == OP_LB[5:3] || p[5:3] == OP_LWC0[5:3]) begin
      r.fields.left_reg = {1'b0, rs};
      r.fields.immediate = zext;
      r.fields.dest_reg = {1'b0, rt};
      r.fields.access_kind = ACC_READ;
      if (p[5:3] == OP_LWC0[5:3]) r.fields.writeback_unit = p[2:0];
    end else if (p[5:4] == OP_COP0[5:4]) begin
      r.fields.coproc_function = rs;
      if (rs < CP_MT) begin
        r.fields.dest_reg = {1'b0, rt};
        r.fields.left_reg = {1'b0, rd} + ctl;
      end else if (rs < CP_BC) begin
        r.fields.writeback_unit = p[2:0];
        r.fields.dest_reg = {1'b0, rd} + ctl;
        r.fields.left_reg = {1'b0, rt};
      end else if (rs == CP_BC) begin
        r.fields.right_reg = rt;
        r.fields.immediate = sext;
      end else if (rs[4]) begin
        r.fields.immediate = {7'h0, w[24:0]};
      end
    end else begin
      // stores and swc share one shape
      r.fields.left_reg = {1'b0, rs};
      r.fields.right_reg = rt;
      r.fields.immediate = zext;
      r.fields.access_kind = ACC_WRITE;
    end
    return r;
  endfunction

  // valid is raised at a rising edge; in_ready is looked at on the falling edge,
  // where it is settled for the edge that follows
  task automatic send_instr(input logic [31:0] word, input logic [31:0] addr);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= word;
    in_instruction_address <= addr;
    forever begin
      @(negedge clk);
      if (in_ready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    pending_decodes.push_back(predict_decode(word, addr));
    sent_count++;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin : result_check
    decoded_instr_t got;
    decoded_instr_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_primary_op, out_secondary_op, out_left_reg, out_right_reg, out_dest_reg,
             out_link_reg, out_immediate, out_access_kind, out_coproc_function,
             out_writeback_unit, out_decoded_address};
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("error: result with none pending, op %h fn %h addr %h",
                   got.fields.primary_op, got.fields.secondary_op, got.address);
      end else begin
        want = pending_decodes.pop_front();
        checked_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("error: decode mismatch at addr %h", want.address);
            $display("  exp op %h fn %h l %h r %h d %h lk %h imm %h acc %h cf %h wb %h a %h",
                     want.fields.primary_op, want.fields.secondary_op,
                     want.fields.left_reg, want.fields.right_reg, want.fields.dest_reg,
                     want.fields.link_reg, want.fields.immediate, want.fields.access_kind,
                     want.fields.coproc_function, want.fields.writeback_unit,
                     want.address);
            $display("  got op %h fn %h l %h r %h d %h lk %h imm %h acc %h cf %h wb %h a %h",
                     got.fields.primary_op, got.fields.secondary_op,
                     got.fields.left_reg, got.fields.right_reg, got.fields.dest_reg,
                     got.fields.link_reg, got.fields.immediate, got.fields.access_kind,
                     got.fields.coproc_function, got.fields.writeback_unit,
                     got.address);
          end
        end
      end
    end
  end

  task automatic test_directed_classes();
    idle_en = 1'b0;
    send_instr(32'h0000_0000, 32'h0000_0000);
    send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(enc_r(OP_SPECIAL, 5'd5, 5'd31, 5'd17, 5'd31, FN_SRA), 32'hBFC0_0000);
    send_instr(enc_r(OP_SPECIAL, 5'd31, 5'd2, 5'd3, 5'd0, FN_SRAV), 32'h8000_0004);
    send_instr(enc_r(OP_SPECIAL, 5'd31, 5'd0, 5'd0, 5'd0, FN_JR), 32'h8000_0008);
    send_instr(enc_r(OP_SPECIAL, 5'd4, 5'd0, 5'd31, 5'd0, FN_JALR), 32'h8000_000C);
    send_instr({OP_SPECIAL, 20'hFFFFF, FN_BREAK}, 32'h8000_0010);
    send_instr(enc_r(OP_SPECIAL, 5'd0, 5'd0, 5'd9, 5'd0, FN_MFLO), 32'h8000_0014);
    send_instr(enc_r(OP_SPECIAL, 5'd7, 5'd0, 5'd0, 5'd0, FN_MTHI), 32'h8000_0018);
    send_instr(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIVU), 32'h8000_001C);
    send_instr(enc_r(OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, FN_LAST), 32'h8000_0020);
    // sync is an unrecognised function code and gives an empty decode; movci decodes as a shift
    send_instr(enc_r(OP_SPECIAL, 5'd3, 5'd4, 5'd5, 5'd0, FN_SYNC), 32'h8000_0024);
    send_instr(enc_r(OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, FN_MOVCI), 32'h8000_0028);
    send_instr(enc_i(OP_REGIMM, 5'd8, 5'd17, 16'h8000), 32'h0040_0000);
    send_instr({OP_JAL, 26'h3FFFFFF}, 32'h0040_0004);
    send_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'hFFFF), 32'h0040_0008);
    send_instr(enc_i(OP_BGTZ, 5'd3, 5'd0, 16'h7FFF), 32'h0040_000C);
    // lui keeps its rs out of left_reg and is not sign-extended
    send_instr(enc_i(OP_LUI, 5'd31, 5'd9, 16'hFFFF), 32'h0040_0010);
    send_instr(enc_i(OP_XORI, 5'd2, 5'd3, 16'h8001), 32'h0040_0014);
    send_instr(enc_i(OP_LW, 5'd29, 5'd8, 16'hFFFC), 32'h0040_0018);
    send_instr(enc_i(OP_SW, 5'd29, 5'd31, 16'h8000), 32'h0040_001C);
    send_instr(enc_r(OP_COP0, CP_MF, 5'd4, 5'd12, 5'd0, 6'h00), 32'h0040_0020);
    send_instr(enc_r(OP_COP1, CP_CF, 5'd5, 5'd31, 5'd0, 6'h00), 32'h0040_0024);
    send_instr(enc_r(OP_COP2, CP_CT, 5'd7, 5'd31, 5'd0, 6'h00), 32'h0040_0028);
    send_instr(enc_r(OP_COP3, CP_MT, 5'd31, 5'd1, 5'd0, 6'h00), 32'h0040_002C);
    send_instr(enc_i(OP_COP1, CP_BC, 5'd1, 16'h8000), 32'h0040_0030);
    // rs between the branch code and the co-op range sets the function only
    send_instr(enc_i(OP_COP0, 5'd13, 5'd31, 16'hFFFF), 32'h0040_0034);
    send_instr({OP_COP2, 1'b1, 25'h1FFFFFF}, 32'h0040_0038);
    send_instr(enc_i(OP_LWC1, 5'd4, 5'd6, 16'hFFFF), 32'h0040_003C);
    send_instr(enc_i(OP_SWC2, 5'd4, 5'd6, 16'h8000), 32'h0040_0040);
    directed_count = sent_count;
  endtask

  task automatic test_special_functions(input int unsigned n);
    logic [5:0] fn;
    idle_en = 1'b1;
    repeat (n) begin
      fn = 6'($urandom_range(0, 63));
      send_instr({OP_SPECIAL, 20'($urandom), fn}, $urandom);
    end
  endtask

  task automatic test_coprocessor_ops(input int unsigned n);
    logic [5:0] op;
    logic [4:0] rs;
    idle_en = 1'b1;
    repeat (n) begin
      op = OP_COP0 + 6'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: rs = 5'($urandom_range(0, 7));
        1: rs = CP_BC;
        2: rs = 5'($urandom_range(9, 15));
        default: rs = 5'($urandom_range(CP_CO, 31));
      endcase
      send_instr({op, rs, 21'($urandom)}, $urandom);
    end
  endtask

  task automatic test_random_words(input int unsigned n, input bit with_idle);
    idle_en = with_idle;
    repeat (n) send_instr($urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_classes();
    test_special_functions(300);
    test_coprocessor_ops(300);
    test_random_words(200, 1'b0);
    test_random_words(500, 1'b1);
    test_random_words(300, 1'b0);
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      mismatch_count += pending_decodes.size();
      $display("error: %0d decodes never came out", pending_decodes.size());
    end
    $display("Sent %0d instruction words (%0d directed, the rest random), %0d decodes checked",
             sent_count, directed_count, checked_count);
    $display("Mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mifd_pkg.sv
hw/rtl/mifd_decode.sv
hw/rtl/mips_instruction_field_decoder_core.sv
dv/mips_instruction_field_decoder_core_tb.sv
